// ===== rtl/core/rsi_pkg.sv =====
// shared widths, latencies and constants for the ray/sphere intersection pipeline
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

    localparam int FRAC    = 16;             // fraction bits of all fixed-point values
    localparam int IN_W    = 32;
    localparam int S_W     = IN_W + 1;       // origin minus centre
    localparam int R_W     = 31;
    localparam int TAG_W   = 16;
    localparam int OUT_W   = 32;

    localparam int MW      = 52;             // multiplier operand width
    localparam int HW      = MW / 2;         // partial product operand width
    localparam int PW      = 2 * MW;         // full product width
    localparam int MUL_LAT = 2;

    localparam int SUM_W   = 70;             // exact dot-product accumulation
    localparam int QW      = 102;            // discriminant width fed to the square root
    localparam int RW      = QW / 2;         // root width, one bit per stage
    localparam int RMW     = RW + 3;         // square root remainder

    localparam int NW      = 54;             // root numerator
    localparam int QB      = OUT_W + 1;      // quotient bits worked out
    localparam int NSH     = QB - FRAC;
    localparam int DRW     = MW + 1;         // divider remainder
    localparam int DIV_LAT = QB + 2;

    localparam int IX_P1    = 1 + MUL_LAT;
    localparam int IX_P2    = IX_P1 + MUL_LAT + 1;
    localparam int IX_P3    = IX_P2 + RW + 1;
    localparam int PIPE_LAT = IX_P3 + DIV_LAT + 1;
    // a and h leave the delay line in the same stage as the root
    localparam int D_AH     = IX_P3 - IX_P1 - 1;

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage
`default_nettype wire

// ===== rtl/core/ray_sphere_intersect_top.sv =====
// Ray/sphere intersection in signed Q16.16, fully pipelined: one ray is taken every cycle
// while the output is not stalled. The depth is set by the square root (one root
// bit per stage, 51 stages) and by the two dividers for the near and far roots (one
// quotient bit per stage plus set-up and saturation, 35 stages), around the dot products
// and discriminant on registered partial-product multipliers. While m_ready is low and a
// result waits, the whole pipeline holds; empty slots never block it. On a miss t_near and
// t_far read zero and the tag is still returned.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_intersect_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_origin_x,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_origin_y,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_origin_z,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_dir_x,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_dir_y,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_dir_z,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_center_x,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_center_y,
    input  logic signed [rsi_pkg::IN_W-1:0]    s_center_z,
    input  logic [rsi_pkg::R_W-1:0]            s_radius,
    input  logic [rsi_pkg::TAG_W-1:0]          s_object_tag,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic signed [rsi_pkg::OUT_W-1:0]   m_t_near,
    output logic signed [rsi_pkg::OUT_W-1:0]   m_t_far,
    output logic [rsi_pkg::TAG_W-1:0]          m_result_tag
);
    import rsi_pkg::*;

    logic en;

    logic                  vld_reg [PIPE_LAT];
    logic [TAG_W-1:0]      tag_reg [PIPE_LAT];
    logic                  hit_reg [IX_P1:PIPE_LAT-1];

    logic signed [S_W-1:0] d_reg [3];
    logic signed [S_W-1:0] s_reg [3];
    logic [R_W-1:0]        r_reg;

    logic signed [PW-1:0]  dd [3];
    logic signed [PW-1:0]  ds [3];
    logic signed [PW-1:0]  ss [3];
    logic signed [PW-1:0]  rr;

    logic signed [SUM_W-1:0] asum, hsum, csum, a_sh, h_sh, c_sh;
    logic signed [MW-1:0]    a_reg, h_reg, c_reg, a_next, h_next, c_next;

    logic signed [PW-1:0]  hh, ac, q;
    logic [QW-1:0]         q_reg, q_next;
    logic                  hit2;

    logic signed [MW-1:0]  a_dly [D_AH];
    logic signed [MW-1:0]  h_dly [D_AH];
    logic [RW-1:0]         root;

    logic signed [NW-1:0]  hx, rx;
    logic signed [NW-1:0]  near_num_reg, far_num_reg;
    logic [MW-1:0]         den_reg;
    logic signed [OUT_W-1:0] near_q, far_q;

    assign en      = !vld_reg[PIPE_LAT-1] || m_ready;
    assign s_ready = en;

    // input stage: direction and origin relative to the centre
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= S_W'(s_dir_x);
            d_reg[1] <= S_W'(s_dir_y);
            d_reg[2] <= S_W'(s_dir_z);
            s_reg[0] <= S_W'(s_origin_x) - S_W'(s_center_x);
            s_reg[1] <= S_W'(s_origin_y) - S_W'(s_center_y);
            s_reg[2] <= S_W'(s_origin_z) - S_W'(s_center_z);
            r_reg    <= s_radius;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        rsi_mul u_dd (.aclk(aclk), .en(en), .x(MW'(d_reg[k])), .y(MW'(d_reg[k])), .p(dd[k]));
        rsi_mul u_ds (.aclk(aclk), .en(en), .x(MW'(d_reg[k])), .y(MW'(s_reg[k])), .p(ds[k]));
        rsi_mul u_ss (.aclk(aclk), .en(en), .x(MW'(s_reg[k])), .y(MW'(s_reg[k])), .p(ss[k]));
    end

    rsi_mul u_rr (
        .aclk (aclk),
        .en   (en),
        .x    ($signed({{(MW-R_W){1'b0}}, r_reg})),
        .y    ($signed({{(MW-R_W){1'b0}}, r_reg})),
        .p    (rr)
    );

    // coefficients, floored back to the working format
    always_comb begin
        asum   = SUM_W'(dd[0]) + SUM_W'(dd[1]) + SUM_W'(dd[2]);
        hsum   = SUM_W'(ds[0]) + SUM_W'(ds[1]) + SUM_W'(ds[2]);
        csum   = SUM_W'(ss[0]) + SUM_W'(ss[1]) + SUM_W'(ss[2]) - SUM_W'(rr);
        a_sh   = asum >>> FRAC;
        h_sh   = hsum >>> FRAC;
        c_sh   = csum >>> FRAC;
        a_next = a_sh[MW-1:0];
        h_next = h_sh[MW-1:0];
        c_next = c_sh[MW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            h_reg <= h_next;
            c_reg <= c_next;
        end
    end

    rsi_mul u_hh (.aclk(aclk), .en(en), .x(h_reg), .y(h_reg), .p(hh));
    rsi_mul u_ac (.aclk(aclk), .en(en), .x(a_reg), .y(c_reg), .p(ac));

    // a miss feeds zero through the root so the divider inputs stay harmless
    always_comb begin
        q      = hh - ac;
        hit2   = hit_reg[IX_P2-1] && !q[PW-1];
        q_next = hit2 ? q[QW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    rsi_sqrt u_sqrt (.aclk(aclk), .en(en), .v(q_reg), .root(root));

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dly[0] <= a_reg;
            h_dly[0] <= h_reg;
            for (int i = 1; i < D_AH; i++) begin
                a_dly[i] <= a_dly[i-1];
                h_dly[i] <= h_dly[i-1];
            end
        end
    end

    always_comb begin
        hx = $signed({{(NW-MW){h_dly[D_AH-1][MW-1]}}, h_dly[D_AH-1]});
        rx = $signed({{(NW-RW){1'b0}}, root});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            near_num_reg <= -hx - rx;
            far_num_reg  <= -hx + rx;
            den_reg      <= a_dly[D_AH-1];
        end
    end

    rsi_div u_div_near (.aclk(aclk), .en(en), .num(near_num_reg), .den(den_reg), .quo(near_q));
    rsi_div u_div_far  (.aclk(aclk), .en(en), .num(far_num_reg),  .den(den_reg), .quo(far_q));

    // item bookkeeping alongside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= s_object_tag;
            for (int i = 1; i < PIPE_LAT; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            hit_reg[IX_P1] <= !a_next[MW-1] && (|a_next);
            for (int i = IX_P1 + 1; i < PIPE_LAT; i++) begin
                hit_reg[i] <= (i == IX_P2) ? hit2 : hit_reg[i-1];
            end
        end
    end

    assign m_valid      = vld_reg[PIPE_LAT-1];
    assign m_hit        = hit_reg[PIPE_LAT-1];
    assign m_t_near     = m_hit ? near_q : '0;
    assign m_t_far      = m_hit ? far_q  : '0;
    assign m_result_tag = tag_reg[PIPE_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/core/rsi_mul.sv =====
// signed multiplier built from four registered partial products, with the product registered again
`timescale 1ns / 1ps
`default_nettype none
module rsi_mul (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [rsi_pkg::MW-1:0]  x,
    input  logic signed [rsi_pkg::MW-1:0]  y,
    output logic signed [rsi_pkg::PW-1:0]  p
);
    import rsi_pkg::*;

    logic [MW-1:0]        xm, ym;
    logic [2*HW-1:0]      ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*HW-1:0]      ll_next, lh_next, hl_next, hh_next;
    logic                 neg_reg, neg_next;
    logic [PW-1:0]        mid, psum;
    logic signed [PW-1:0] p_reg, p_next;

    always_comb begin
        xm       = x[MW-1] ? MW'(-x) : MW'(x);
        ym       = y[MW-1] ? MW'(-y) : MW'(y);
        neg_next = x[MW-1] ^ y[MW-1];
        ll_next  = xm[HW-1:0]  * ym[HW-1:0];
        lh_next  = xm[HW-1:0]  * ym[MW-1:HW];
        hl_next  = xm[MW-1:HW] * ym[HW-1:0];
        hh_next  = xm[MW-1:HW] * ym[MW-1:HW];
    end

    always_comb begin
        mid    = PW'(lh_reg) + PW'(hl_reg);
        psum   = {hh_reg, ll_reg} + (mid << HW);
        p_next = neg_reg ? -$signed(psum) : $signed(psum);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            hl_reg  <= hl_next;
            hh_reg  <= hh_next;
            neg_reg <= neg_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rsi_sqrt.sv =====
// pipelined floor square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rsi_sqrt (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [rsi_pkg::QW-1:0]  v,
    output logic [rsi_pkg::RW-1:0]  root
);
    import rsi_pkg::*;

    logic [RMW-1:0] rem_reg  [RW];
    logic [RMW-1:0] rem_next [RW];
    logic [RW-1:0]  rt_reg   [RW];
    logic [RW-1:0]  rt_next  [RW];
    logic [QW-1:0]  v_reg    [RW];
    logic [QW-1:0]  v_next   [RW];

    always_comb begin
        logic [RMW-1:0] rp, rs, tr;
        logic [RW-1:0]  tp;
        logic [QW-1:0]  vp;
        int             j;
        for (int i = 0; i < RW; i++) begin
            j  = (i == 0) ? 0 : i - 1;
            rp = (i == 0) ? '0 : rem_reg[j];
            tp = (i == 0) ? '0 : rt_reg[j];
            vp = (i == 0) ? v  : v_reg[j];
            rs = {rp[RMW-3:0], vp[QW-1:QW-2]};
            tr = {1'b0, tp, 2'b01};
            if (rs >= tr) begin
                rem_next[i] = rs - tr;
                rt_next[i]  = {tp[RW-2:0], 1'b1};
            end else begin
                rem_next[i] = rs;
                rt_next[i]  = {tp[RW-2:0], 1'b0};
            end
            v_next[i] = {vp[QW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < RW; i++) begin
                rem_reg[i] <= rem_next[i];
                rt_reg[i]  <= rt_next[i];
                v_reg[i]   <= v_next[i];
            end
        end
    end

    assign root = rt_reg[RW-1];

endmodule
`default_nettype wire

// ===== rtl/core/rsi_div.sv =====
// pipelined restoring divider giving (num * 2^frac) / den, truncated and saturated
`timescale 1ns / 1ps
`default_nettype none
module rsi_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [rsi_pkg::NW-1:0]     num,
    input  logic [rsi_pkg::MW-1:0]            den,
    output logic signed [rsi_pkg::OUT_W-1:0]  quo
);
    import rsi_pkg::*;

    logic [NW-1:0]  mag, hi;
    logic [DRW-1:0] p_rem_reg, p_rem_next;
    logic [QB-1:0]  p_nl_reg, p_nl_next;
    logic [MW-1:0]  p_den_reg;
    logic           p_ovf_reg, p_ovf_next, p_neg_reg;

    logic [DRW-1:0] rem_reg  [QB];
    logic [DRW-1:0] rem_next [QB];
    logic [QB-1:0]  q_reg    [QB];
    logic [QB-1:0]  q_next   [QB];
    logic [QB-1:0]  nl_reg   [QB];
    logic [QB-1:0]  nl_next  [QB];
    logic [MW-1:0]  den_reg  [QB];
    logic           ovf_reg  [QB];
    logic           neg_reg  [QB];

    logic [OUT_W-1:0] quo_reg, quo_next;

    // quotient of 2^QB or more can only saturate
    always_comb begin
        mag        = num[NW-1] ? NW'(-num) : NW'(num);
        hi         = mag >> NSH;
        p_ovf_next = hi >= {{(NW-MW){1'b0}}, den};
        p_rem_next = hi[DRW-1:0];
        p_nl_next  = {mag[NSH-1:0], {FRAC{1'b0}}};
    end

    always_comb begin
        logic [DRW-1:0] rp, rs, dz;
        logic [QB-1:0]  qp, nlp;
        int             j;
        for (int i = 0; i < QB; i++) begin
            j   = (i == 0) ? 0 : i - 1;
            rp  = (i == 0) ? p_rem_reg : rem_reg[j];
            qp  = (i == 0) ? '0        : q_reg[j];
            nlp = (i == 0) ? p_nl_reg  : nl_reg[j];
            dz  = (i == 0) ? {1'b0, p_den_reg} : {1'b0, den_reg[j]};
            rs  = {rp[DRW-2:0], nlp[QB-1]};
            if (rs >= dz) begin
                rem_next[i] = rs - dz;
                q_next[i]   = {qp[QB-2:0], 1'b1};
            end else begin
                rem_next[i] = rs;
                q_next[i]   = {qp[QB-2:0], 1'b0};
            end
            nl_next[i] = {nlp[QB-2:0], 1'b0};
        end
    end

    always_comb begin
        logic [QB-1:0] qf;
        logic          big;
        qf  = q_reg[QB-1];
        big = ovf_reg[QB-1] || (|qf[QB-1:OUT_W-1]);
        if (neg_reg[QB-1]) begin
            quo_next = big ? SAT_MIN : OUT_W'(-qf[OUT_W-1:0]);
        end else begin
            quo_next = big ? SAT_MAX : qf[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_rem_reg <= p_rem_next;
            p_nl_reg  <= p_nl_next;
            p_den_reg <= den;
            p_ovf_reg <= p_ovf_next;
            p_neg_reg <= num[NW-1];
            for (int i = 0; i < QB; i++) begin
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
                nl_reg[i]  <= nl_next[i];
            end
            den_reg[0] <= p_den_reg;
            ovf_reg[0] <= p_ovf_reg;
            neg_reg[0] <= p_neg_reg;
            for (int i = 1; i < QB; i++) begin
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rsi_checker.sv =====
// port-level checks for the intersection pipeline, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module rsi_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_hit,
    input  logic signed [rsi_pkg::OUT_W-1:0]   m_t_near,
    input  logic signed [rsi_pkg::OUT_W-1:0]   m_t_far,
    input  logic [rsi_pkg::TAG_W-1:0]          m_result_tag
);
    import rsi_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_t_near)
                                && $stable(m_t_far) && $stable(m_result_tag))
        else $error("stalled item changed or dropped");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_t_near == '0 && m_t_far == '0)
        else $error("miss with non-zero roots");

    a_root_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_t_near <= m_t_far)
        else $error("near root beyond far root");

endmodule

bind ray_sphere_intersect_top rsi_checker u_rsi_checker (.*);
`default_nettype wire
